[rtl/cal_pkg.sv]
// ----------------------------------------------------------------------------
// cal_pkg: shared types and codes for the cursor array list
// Command codes and the packed layouts of the input and result words.
// ----------------------------------------------------------------------------
`default_nettype none

package cal_pkg;

  localparam int ACTION_BITS = 4;
  localparam int VALUE_BITS  = 32;
  localparam int INDEX_BITS  = 5;
  localparam int COUNT_BITS  = 6;

  // command codes
  localparam logic [ACTION_BITS-1:0] ACT_START        = 4'd0;
  localparam logic [ACTION_BITS-1:0] ACT_ADVANCE      = 4'd1;
  localparam logic [ACTION_BITS-1:0] ACT_END          = 4'd2;
  localparam logic [ACTION_BITS-1:0] ACT_INSERT       = 4'd3;
  localparam logic [ACTION_BITS-1:0] ACT_ATTACH       = 4'd4;
  localparam logic [ACTION_BITS-1:0] ACT_REMOVE       = 4'd5;
  localparam logic [ACTION_BITS-1:0] ACT_INSERT_FRONT = 4'd6;
  localparam logic [ACTION_BITS-1:0] ACT_REMOVE_FRONT = 4'd7;
  localparam logic [ACTION_BITS-1:0] ACT_APPEND       = 4'd8;
  localparam logic [ACTION_BITS-1:0] ACT_READ_CURRENT = 4'd9;
  localparam logic [ACTION_BITS-1:0] ACT_READ_INDEX   = 4'd10;

  // input word, action in the lowest bits
  typedef struct packed {
    logic [INDEX_BITS-1:0]  read_index;
    logic [VALUE_BITS-1:0]  entry_value;
    logic [ACTION_BITS-1:0] action;
  } cmd_t;

  // result word, result_value in the lowest bits
  typedef struct packed {
    logic                  refused;
    logic [COUNT_BITS-1:0] entry_count;
    logic                  has_current;
    logic [VALUE_BITS-1:0] result_value;
  } res_t;

  localparam int CMD_BITS = $bits(cmd_t);
  localparam int RES_BITS = $bits(res_t);

endpackage

`default_nettype wire

[rtl/cursor_array_list.sv]
// ----------------------------------------------------------------------------
// cursor_array_list: ordered word list with a cursor
// Commands move the cursor, insert, attach, remove, append or read entries.
//
//   port group  dir  payload (low bit first)
//   s_*         in   action[3:0], entry_value[35:4], read_index[40:36]
//   m_*         out  result_value[31:0], has_current[32], entry_count[38:33],
//                    refused[39]
//
// One command at a time. A command that opens or closes a gap moves the
// entries one place each, one entry at a time, each read and then written
// back through the single memory read port and single write port. rst is
// synchronous and empties the list. A stalled result word holds in the
// output register; the next command is taken while it waits, and its result
// waits until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_array_list #(
  parameter int CAPACITY_WORDS = 32,
  parameter int WORD_BITS      = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // action, entry_value, read_index
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata    // result_value, has_current, entry_count,
                                      // refused
);

  import cal_pkg::*;

  localparam int AW = $clog2(CAPACITY_WORDS);
  localparam int CW = $clog2(CAPACITY_WORDS + 1);

  cmd_t                 cmd;
  res_t                 res;
  logic                 cmd_ready;
  logic                 res_valid;
  logic                 out_free;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;
  logic [RES_BITS-1:0]  out_word;

  assign cmd      = cmd_t'(s_tdata[CMD_BITS-1:0]);
  assign s_tready = cmd_ready;
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = out_word;

  cal_seq #(
    .CAPACITY_WORDS (CAPACITY_WORDS),
    .WORD_BITS      (WORD_BITS),
    .AW             (AW),
    .CW             (CW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (s_tvalid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  cal_mem #(
    .DEPTH (CAPACITY_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_word <= res;
    end
  end

endmodule

`default_nettype wire

[rtl/cal_mem.sv]
// ----------------------------------------------------------------------------
// cal_mem: entry storage
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/cal_seq.sv]
// ----------------------------------------------------------------------------
// cal_seq: command sequencer
// Decodes one command, keeps count and cursor, and moves entries one place
// per pass through a shared index stepper and the storage ports.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_seq #(
  parameter int CAPACITY_WORDS = 32,
  parameter int WORD_BITS      = 32,
  parameter int AW             = 5,
  parameter int CW             = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  input  wire cal_pkg::cmd_t        cmd,
  output logic                      cmd_ready,
  input  wire logic                 out_free,
  output logic                      res_valid,
  output cal_pkg::res_t             res,
  output logic                      mem_we,
  output logic      [AW-1:0]        mem_waddr,
  output logic      [WORD_BITS-1:0] mem_wdata,
  output logic      [AW-1:0]        mem_raddr,
  input  wire logic [WORD_BITS-1:0] mem_rdata
);

  import cal_pkg::*;

  localparam int CMPW = (CW > INDEX_BITS) ? CW + 1 : INDEX_BITS + 1;

  // state codes
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_OPEN_RD  = 3'd1;
  localparam logic [2:0] ST_OPEN_WR  = 3'd2;
  localparam logic [2:0] ST_CLOSE_RD = 3'd3;
  localparam logic [2:0] ST_CLOSE_WR = 3'd4;
  localparam logic [2:0] ST_READ     = 3'd5;
  localparam logic [2:0] ST_GET      = 3'd6;
  localparam logic [2:0] ST_FIN      = 3'd7;

  logic [2:0]            state, state_next;
  logic [CW:0]           cur, cur_next;      // MSB set means no current entry
  logic [CW-1:0]         cnt, cnt_next;
  logic [AW-1:0]         idx, idx_next;      // walking position
  logic [AW-1:0]         lim, lim_next;      // where the walk stops
  logic [WORD_BITS-1:0]  val, val_next;
  logic [VALUE_BITS-1:0] res_value, res_value_next;
  logic                  refused, refused_next;

  logic                  has_entry;
  logic                  full;
  logic [AW-1:0]         cur_pos;
  logic [AW-1:0]         idx_step;
  logic                  idx_ok;

  assign has_entry = !cur[CW] && (cur[CW-1:0] < cnt);
  assign full      = (cnt >= CW'(CAPACITY_WORDS));
  assign cur_pos   = cur[AW-1:0];
  assign idx_ok    = (CMPW'(cmd.read_index) < CMPW'(cnt)) &&
                     (CMPW'(cmd.read_index) < CMPW'(CAPACITY_WORDS));

  // shared stepper: up while closing a gap, down while opening one
  assign idx_step = (state == ST_CLOSE_RD || state == ST_CLOSE_WR) ?
                    idx + AW'(1) : idx - AW'(1);

  assign cmd_ready = (state == ST_IDLE);

  // result word from the settled state
  assign res.result_value = res_value;
  assign res.has_current  = has_entry;
  assign res.entry_count  = COUNT_BITS'(cnt);
  assign res.refused      = refused;

  // sequencer
  always_comb begin
    state_next     = state;
    cur_next       = cur;
    cnt_next       = cnt;
    idx_next       = idx;
    lim_next       = lim;
    val_next       = val;
    res_value_next = res_value;
    refused_next   = refused;
    mem_we         = 1'b0;
    mem_waddr      = idx;
    mem_wdata      = val;
    mem_raddr      = idx;
    res_valid      = 1'b0;

    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          val_next       = WORD_BITS'(cmd.entry_value);
          res_value_next = '0;
          refused_next   = 1'b0;
          state_next     = ST_FIN;
          case (cmd.action)
            ACT_START: begin
              cur_next = '0;
            end
            ACT_ADVANCE: begin
              if (has_entry) begin
                cur_next = cur + (CW+1)'(1);
              end else begin
                cur_next     = '1;
                refused_next = 1'b1;
              end
            end
            ACT_END: begin
              cur_next = {1'b0, cnt} - (CW+1)'(1);
            end
            ACT_INSERT: begin
              if (full) begin
                refused_next = 1'b1;
              end else begin
                idx_next   = cnt[AW-1:0];
                lim_next   = has_entry ? cur_pos : '0;
                cnt_next   = cnt + CW'(1);
                state_next = ST_OPEN_RD;
                if (!has_entry) begin
                  cur_next = '0;
                end
              end
            end
            ACT_ATTACH: begin
              if (full) begin
                refused_next = 1'b1;
              end else begin
                idx_next   = cnt[AW-1:0];
                cnt_next   = cnt + CW'(1);
                state_next = ST_OPEN_RD;
                if (has_entry) begin
                  lim_next = cur_pos + AW'(1);
                  cur_next = cur + (CW+1)'(1);
                end else begin
                  lim_next = cnt[AW-1:0];
                  cur_next = {1'b0, cnt};
                end
              end
            end
            ACT_REMOVE: begin
              if (has_entry) begin
                idx_next   = cur_pos;
                lim_next   = AW'(cnt - CW'(1));
                cnt_next   = cnt - CW'(1);
                state_next = ST_CLOSE_RD;
              end else begin
                refused_next = 1'b1;
              end
            end
            ACT_INSERT_FRONT: begin
              if (full) begin
                refused_next = 1'b1;
              end else begin
                idx_next   = cnt[AW-1:0];
                lim_next   = '0;
                cnt_next   = cnt + CW'(1);
                cur_next   = '0;
                state_next = ST_OPEN_RD;
              end
            end
            ACT_REMOVE_FRONT: begin
              if (cnt != '0) begin
                idx_next   = '0;
                lim_next   = AW'(cnt - CW'(1));
                cnt_next   = cnt - CW'(1);
                cur_next   = '0;
                state_next = ST_CLOSE_RD;
              end else begin
                refused_next = 1'b1;
              end
            end
            ACT_APPEND: begin
              if (full) begin
                refused_next = 1'b1;
              end else begin
                idx_next   = cnt[AW-1:0];
                lim_next   = cnt[AW-1:0];
                cnt_next   = cnt + CW'(1);
                state_next = ST_OPEN_RD;
              end
            end
            ACT_READ_CURRENT: begin
              if (has_entry) begin
                idx_next   = cur_pos;
                state_next = ST_READ;
              end else begin
                refused_next = 1'b1;
              end
            end
            ACT_READ_INDEX: begin
              if (idx_ok) begin
                idx_next   = AW'(cmd.read_index);
                state_next = ST_READ;
              end else begin
                refused_next = 1'b1;
              end
            end
            default: begin
              refused_next = 1'b1;
            end
          endcase
        end
      end

      // shift entries back one place, top down, then drop in the new word
      ST_OPEN_RD: begin
        if (idx > lim) begin
          mem_raddr  = idx_step;
          state_next = ST_OPEN_WR;
        end else begin
          mem_we     = 1'b1;
          mem_wdata  = val;
          state_next = ST_FIN;
        end
      end
      ST_OPEN_WR: begin
        mem_we     = 1'b1;
        mem_wdata  = mem_rdata;
        idx_next   = idx_step;
        state_next = ST_OPEN_RD;
      end

      // shift later entries forward one place, bottom up
      ST_CLOSE_RD: begin
        if (idx < lim) begin
          mem_raddr  = idx_step;
          state_next = ST_CLOSE_WR;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_CLOSE_WR: begin
        mem_we     = 1'b1;
        mem_wdata  = mem_rdata;
        idx_next   = idx_step;
        state_next = ST_CLOSE_RD;
      end

      // single read
      ST_READ: begin
        state_next = ST_GET;
      end
      ST_GET: begin
        res_value_next = VALUE_BITS'(mem_rdata);
        state_next     = ST_FIN;
      end

      // hand the result word over once the output slot is free
      ST_FIN: begin
        if (out_free) begin
          res_valid  = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cur   <= '1;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      cnt   <= cnt_next;
    end
  end

  // walk and payload registers
  always_ff @(posedge clk) begin
    idx       <= idx_next;
    lim       <= lim_next;
    val       <= val_next;
    res_value <= res_value_next;
    refused   <= refused_next;
  end

endmodule

`default_nettype wire

[rtl/cal_check.sv]
// ----------------------------------------------------------------------------
// cal_check: port-level checks for the cursor array list
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_check #(
  parameter int CAPACITY_WORDS = 32
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  // one command at a time: busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after an accepted word");

  // a refused command reads nothing
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[39]) |-> (m_tdata[31:0] == 32'd0))
    else $error("refused word carries a nonzero value");

  // count stays within capacity, and a current entry needs a nonempty list
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (CAPACITY_WORDS >= 64) ||
                 ((m_tdata[38:33] <= CAPACITY_WORDS) &&
                  (!m_tdata[32] || m_tdata[38:33] != 6'd0)))
    else $error("entry count or current flag out of range");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output word changed");

endmodule

bind cursor_array_list cal_check #(
  .CAPACITY_WORDS (CAPACITY_WORDS)
) u_cal_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for cursor_array_list
// Drives list commands on the s_* stream and checks every result word on the
// m_* stream against an in-bench list predictor or a typed row's own word.
// A directed table covers the empty-list and boundary cases first. Random
// runs then grow, shrink and walk the list under several idle and stall mixes.
// ----------------------------------------------------------------------------

module testbench;
  import cal_pkg::*;

  localparam int LIST_DEPTH     = 32;
  localparam int S_BITS         = 48;
  localparam int M_BITS         = 40;
  localparam int RAND_ITEMS     = 830;
  localparam int HOLD_AT        = 100;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_AT       = 600;
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 3000;

  // codes the block does not define; all are refused
  localparam logic [ACTION_BITS-1:0] ACT_FIRST_UNUSED = ACT_READ_INDEX + 4'd1;
  localparam logic [ACTION_BITS-1:0] ACT_LAST_CODE    = '1;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED, MODE_WALK} mode_e;

  // one directed row; the expected word is used only when typed is set
  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic [VALUE_BITS-1:0]  value;
    logic [INDEX_BITS-1:0]  idx;
    logic                   typed;
    res_t                   want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [S_BITS-1:0] s_tdata = '0;   // action, entry_value, read_index
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [M_BITS-1:0] m_tdata;        // result_value, has_current, entry_count,
                                     // refused

  cursor_array_list dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // list predictor state
  logic [VALUE_BITS-1:0] model_words [LIST_DEPTH];
  int                    model_len    = 0;
  int                    model_cursor = -1;

  res_t     pending_results [$];
  dir_row_t dir_rows [$];
  int       mismatch_count = 0;
  int       tx_idle_pct    = 0;
  int       rx_stall_pct   = 0;
  int       hold_left      = 0;
  int       quiet_cycles   = 0;
  res_t     got_res;
  res_t     want_res;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic logic cursor_valid();
    return model_len > 0 && model_cursor >= 0 && model_cursor < model_len;
  endfunction

  // shift entries pos..len-1 back one and place the word at pos
  function automatic void make_room(input int pos, input logic [VALUE_BITS-1:0] v);
    int i;
    for (i = model_len; i > pos; i--) model_words[i] = model_words[i-1];
    model_words[pos] = v;
    model_len++;
  endfunction

  // drop the entry at pos, pulling later entries forward
  function automatic void close_up(input int pos);
    int i;
    for (i = pos; i < model_len - 1; i++) model_words[i] = model_words[i+1];
    model_len--;
  endfunction

  // apply one command to the predicted list and return its result word
  function automatic res_t apply_list_cmd(input cmd_t c);
    res_t r;
    logic full;
    logic cur_ok;
    r = '0;
    full = model_len >= LIST_DEPTH;
    cur_ok = cursor_valid();
    case (c.action)
      ACT_START: model_cursor = 0;
      ACT_ADVANCE: begin
        if (cur_ok) begin
          model_cursor++;
        end else begin
          model_cursor = -1;
          r.refused = 1'b1;
        end
      end
      ACT_END: model_cursor = model_len - 1;
      ACT_INSERT: begin
        if (full) begin
          r.refused = 1'b1;
        end else if (cur_ok) begin
          make_room(model_cursor, c.entry_value);
        end else begin
          make_room(0, c.entry_value);
          model_cursor = 0;
        end
      end
      ACT_ATTACH: begin
        if (full) begin
          r.refused = 1'b1;
        end else if (cur_ok) begin
          make_room(model_cursor + 1, c.entry_value);
          model_cursor++;
        end else begin
          model_cursor = model_len;
          make_room(model_len, c.entry_value);
        end
      end
      ACT_REMOVE: begin
        if (cur_ok) close_up(model_cursor);
        else r.refused = 1'b1;
      end
      ACT_INSERT_FRONT: begin
        if (full) begin
          r.refused = 1'b1;
        end else begin
          make_room(0, c.entry_value);
          model_cursor = 0;
        end
      end
      ACT_REMOVE_FRONT: begin
        if (model_len > 0) begin
          close_up(0);
          model_cursor = 0;
        end else begin
          r.refused = 1'b1;
        end
      end
      ACT_APPEND: begin
        if (full) r.refused = 1'b1;
        else make_room(model_len, c.entry_value);
      end
      ACT_READ_CURRENT: begin
        if (cur_ok) r.result_value = model_words[model_cursor];
        else r.refused = 1'b1;
      end
      ACT_READ_INDEX: begin
        if (int'(c.read_index) < model_len) r.result_value = model_words[c.read_index];
        else r.refused = 1'b1;
      end
      default: r.refused = 1'b1;
    endcase
    r.has_current = cursor_valid();
    r.entry_count = model_len[COUNT_BITS-1:0];
    return r;
  endfunction

  task automatic add_row(input logic [ACTION_BITS-1:0] action,
                         input logic [VALUE_BITS-1:0] value,
                         input logic [INDEX_BITS-1:0] idx, input logic typed,
                         input logic [VALUE_BITS-1:0] rv, input logic hc,
                         input logic [COUNT_BITS-1:0] cnt, input logic rf);
    dir_row_t row;
    row.action = action;
    row.value = value;
    row.idx = idx;
    row.typed = typed;
    row.want.result_value = rv;
    row.want.has_current = hc;
    row.want.entry_count = cnt;
    row.want.refused = rf;
    dir_rows.push_back(row);
  endtask

  // offer one command word, wait for it to be taken, then log its result
  task automatic send_cmd(input cmd_t c, input logic typed, input res_t typed_res);
    res_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(S_BITS - CMD_BITS){1'b0}}, c};
    do @(posedge clk); while (!s_tready);
    predicted = apply_list_cmd(c);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  function automatic logic [ACTION_BITS-1:0] cursor_move();
    case ($urandom_range(3))
      0: return ACT_START;
      1: return ACT_END;
      default: return ACT_ADVANCE;
    endcase
  endfunction

  function automatic logic [ACTION_BITS-1:0] read_cmd();
    return $urandom_range(1) ? ACT_READ_CURRENT : ACT_READ_INDEX;
  endfunction

  function automatic logic [ACTION_BITS-1:0] pick_action(input mode_e mode);
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return ACTION_BITS'($urandom_range(ACT_LAST_CODE, ACT_FIRST_UNUSED));
    case (mode)
      MODE_GROW: begin
        if (roll < 63) begin
          case ($urandom_range(3))
            0: return ACT_INSERT;
            1: return ACT_ATTACH;
            2: return ACT_INSERT_FRONT;
            default: return ACT_APPEND;
          endcase
        end
        return (roll < 80) ? cursor_move() : read_cmd();
      end
      MODE_SHRINK: begin
        if (roll < 63) return $urandom_range(2) ? ACT_REMOVE : ACT_REMOVE_FRONT;
        return (roll < 80) ? cursor_move() : read_cmd();
      end
      MODE_MIXED: return ACTION_BITS'($urandom_range(ACT_READ_INDEX, ACT_START));
      default: return (roll < 60) ? cursor_move() : read_cmd();
    endcase
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return VALUE_BITS'(1) << $urandom_range(VALUE_BITS - 1);
      default: return $urandom;
    endcase
  endfunction

  // mostly indexes that hold an entry, some past the end
  function automatic logic [INDEX_BITS-1:0] pick_index();
    if (model_len > 0 && $urandom_range(3) != 0)
      return INDEX_BITS'($urandom_range(model_len - 1, 0));
    return INDEX_BITS'($urandom_range(LIST_DEPTH - 1, 0));
  endfunction

  // receiver: random stalls, plus a long hold-off counted here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result word %h with no command pending", m_tdata));
      end else begin
        want_res = pending_results.pop_front();
        got_res = m_tdata[RES_BITS-1:0];
        if (got_res.result_value !== want_res.result_value)
          flag_mismatch($sformatf("result_value got %h want %h",
                                  got_res.result_value, want_res.result_value));
        if (got_res.has_current !== want_res.has_current)
          flag_mismatch($sformatf("has_current got %b want %b",
                                  got_res.has_current, want_res.has_current));
        if (got_res.entry_count !== want_res.entry_count)
          flag_mismatch($sformatf("entry_count got %0d want %0d",
                                  got_res.entry_count, want_res.entry_count));
        if (got_res.refused !== want_res.refused)
          flag_mismatch($sformatf("refused got %b want %b",
                                  got_res.refused, want_res.refused));
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    cmd_t  c;
    mode_e mode;
    int    mode_left;
    int    n;

    // empty list: everything that needs an entry is refused
    add_row(ACT_READ_CURRENT, 32'h0, 5'd0, 1'b1, 32'h0, 1'b0, 6'd0, 1'b1);
    add_row(ACT_ADVANCE, 32'h0, 5'd0, 1'b1, 32'h0, 1'b0, 6'd0, 1'b1);
    add_row(ACT_REMOVE, 32'h0, 5'd0, 1'b1, 32'h0, 1'b0, 6'd0, 1'b1);
    add_row(ACT_REMOVE_FRONT, 32'h0, 5'd0, 1'b1, 32'h0, 1'b0, 6'd0, 1'b1);
    add_row(ACT_READ_INDEX, 32'h0, 5'd0, 1'b1, 32'h0, 1'b0, 6'd0, 1'b1);
    add_row(ACT_END, 32'h0, 5'd0, 1'b1, 32'h0, 1'b0, 6'd0, 1'b0);
    add_row(ACT_START, 32'h0, 5'd0, 1'b1, 32'h0, 1'b0, 6'd0, 1'b0);
    add_row(ACT_LAST_CODE, 32'hFFFF_FFFF, 5'd31, 1'b1, 32'h0, 1'b0, 6'd0, 1'b1);
    // build A5, FF, 00, 5A with the cursor left on the front
    add_row(ACT_INSERT, 32'hFFFF_FFFF, 5'd0, 1'b1, 32'h0, 1'b1, 6'd1, 1'b0);
    add_row(ACT_ATTACH, 32'h0000_0000, 5'd0, 1'b1, 32'h0, 1'b1, 6'd2, 1'b0);
    add_row(ACT_INSERT_FRONT, 32'hA5A5_A5A5, 5'd0, 1'b1, 32'h0, 1'b1, 6'd3, 1'b0);
    add_row(ACT_APPEND, 32'h5A5A_5A5A, 5'd0, 1'b1, 32'h0, 1'b1, 6'd4, 1'b0);
    add_row(ACT_READ_INDEX, 32'h0, 5'd31, 1'b1, 32'h0, 1'b1, 6'd4, 1'b1);
    add_row(ACT_READ_INDEX, 32'h0, 5'd3, 1'b1, 32'h5A5A_5A5A, 1'b1, 6'd4, 1'b0);
    add_row(ACT_END, 32'h0, 5'd0, 1'b1, 32'h0, 1'b1, 6'd4, 1'b0);
    add_row(ACT_READ_CURRENT, 32'h0, 5'd0, 1'b1, 32'h5A5A_5A5A, 1'b1, 6'd4, 1'b0);
    // step off the last entry, then attach with no current entry and insert
    add_row(ACT_ADVANCE, 32'h0, 5'd0, 1'b1, 32'h0, 1'b0, 6'd4, 1'b0);
    add_row(ACT_ATTACH, 32'h1234_5678, 5'd0, 1'b0, 32'h0, 1'b0, 6'd0, 1'b0);
    add_row(ACT_INSERT, 32'h8000_0001, 5'd0, 1'b0, 32'h0, 1'b0, 6'd0, 1'b0);
    add_row(ACT_REMOVE, 32'h0, 5'd0, 1'b0, 32'h0, 1'b0, 6'd0, 1'b0);
    add_row(ACT_READ_CURRENT, 32'h0, 5'd0, 1'b0, 32'h0, 1'b0, 6'd0, 1'b0);
    add_row(ACT_REMOVE_FRONT, 32'h0, 5'd0, 1'b0, 32'h0, 1'b0, 6'd0, 1'b0);
    // removing the last entry leaves no current entry
    add_row(ACT_END, 32'h0, 5'd0, 1'b0, 32'h0, 1'b0, 6'd0, 1'b0);
    add_row(ACT_REMOVE, 32'h0, 5'd0, 1'b0, 32'h0, 1'b0, 6'd0, 1'b0);
    add_row(ACT_READ_INDEX, 32'h0, 5'd0, 1'b0, 32'h0, 1'b0, 6'd0, 1'b0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      c.action = dir_rows[i].action;
      c.entry_value = dir_rows[i].value;
      c.read_index = dir_rows[i].idx;
      send_cmd(c, dir_rows[i].typed, dir_rows[i].want);
    end

    // random runs in grow, shrink, mixed and walk modes
    mode = MODE_GROW;
    mode_left = 0;
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n < 150) begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end else if (n < 350) begin
        tx_idle_pct = 61;
        rx_stall_pct = 0;
      end else if (n < 550) begin
        tx_idle_pct = 0;
        rx_stall_pct = 61;
      end else if (n < 750) begin
        tx_idle_pct = 21;
        rx_stall_pct = 21;
      end else begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end
      if (n == HOLD_AT) hold_left = HOLD_CYCLES;
      if (n == DRAIN_AT) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      if (mode_left == 0) begin
        mode = mode_e'($urandom_range(MODE_WALK, MODE_GROW));
        mode_left = $urandom_range(40, 10);
      end
      mode_left--;
      c.action = pick_action(mode);
      c.entry_value = pick_value();
      c.read_index = pick_index();
      send_cmd(c, 1'b0, '0);
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
